/* design/mutf8_pkg.sv */
`timescale 1ns / 1ps

package mutf8_pkg;

  typedef enum logic [1:0] {
    PhLenHi = 2'd0,
    PhLenLo = 2'd1,
    PhData  = 2'd2,
    PhSkip  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    StChar  = 3'd0,
    StEmpty = 3'd1,
    StTrunc = 3'd2,
    StBadC  = 3'd3,
    StBadL  = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] code_unit;
    status_e     status;
    logic        last;
  } result_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContMatch = 8'h80;
  localparam logic [7:0] AsciiMax  = 8'd127;

endpackage

/* design/mutf8_front.sv */
`timescale 1ns / 1ps

module mutf8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          data_byte_i,
  output logic                push_o,
  output mutf8_pkg::result_t  result_o
);
  import mutf8_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] left_q, left_d;
  logic [1:0]  cont_q, cont_d;
  logic [15:0] part_q, part_d;
  logic        bad_q, bad_d;

  logic [15:0] rem;
  logic [15:0] len;
  logic        bad_n;
  logic [1:0]  cont_n;
  logic [15:0] part_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhLenHi;
      len_hi_q <= '0;
      left_q   <= '0;
      cont_q   <= '0;
      part_q   <= '0;
      bad_q    <= 1'b0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
      cont_q   <= cont_d;
      part_q   <= part_d;
      bad_q    <= bad_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    len_hi_d = len_hi_q;
    left_d   = left_q;
    cont_d   = cont_q;
    part_d   = part_q;
    bad_d    = bad_q;
    push_o   = 1'b0;
    result_o = '{code_unit: 16'd0, status: StChar, last: 1'b0};

    rem    = left_q - 16'd1;
    len    = {len_hi_q, data_byte_i};
    bad_n  = bad_q | ((data_byte_i & ContMask) != ContMatch);
    cont_n = cont_q - 2'd1;
    part_n = part_q | ({10'd0, data_byte_i[5:0]} << ((cont_n == 2'd1) ? 6 : 0));

    case (phase_q)
      PhLenHi: begin
        len_hi_d = data_byte_i;
        phase_d  = PhLenLo;
      end
      PhLenLo: begin
        cont_d = '0;
        bad_d  = 1'b0;
        part_d = '0;
        if (len == 16'd0) begin
          left_d   = '0;
          phase_d  = PhLenHi;
          push_o   = 1'b1;
          result_o = '{code_unit: 16'd0, status: StEmpty, last: 1'b1};
        end else begin
          left_d  = len;
          phase_d = PhData;
        end
      end
      PhSkip: begin
        left_d = rem;
        if (rem == 16'd0) begin
          phase_d = PhLenHi;
        end
      end
      PhData: begin
        left_d = rem;
        if (cont_q == 2'd0) begin
          if (data_byte_i <= AsciiMax) begin
            if (rem == 16'd0) begin
              phase_d = PhLenHi;
            end
            push_o   = 1'b1;
            result_o = '{code_unit: {8'd0, data_byte_i}, status: StChar,
                         last: (rem == 16'd0)};
          end else if (data_byte_i[7:5] == 3'b110 && rem != 16'd0) begin
            part_d = {5'd0, data_byte_i[4:0], 6'd0};
            cont_d = 2'd1;
            bad_d  = 1'b0;
          end else if (data_byte_i[7:4] == 4'b1110 && rem > 16'd1) begin
            part_d = {data_byte_i[3:0], 12'd0};
            cont_d = 2'd2;
            bad_d  = 1'b0;
          end else begin
            cont_d   = '0;
            bad_d    = 1'b0;
            part_d   = '0;
            phase_d  = (rem != 16'd0) ? PhSkip : PhLenHi;
            push_o   = 1'b1;
            result_o = '{code_unit: 16'd0,
                         status: (data_byte_i[7:5] == 3'b110 ||
                                  data_byte_i[7:4] == 4'b1110) ? StTrunc : StBadL,
                         last: 1'b1};
          end
        end else begin
          cont_d = cont_n;
          part_d = part_n;
          bad_d  = bad_n;
          if (cont_n == 2'd0) begin
            push_o = 1'b1;
            part_d = '0;
            if (bad_n) begin
              cont_d   = '0;
              bad_d    = 1'b0;
              phase_d  = (rem != 16'd0) ? PhSkip : PhLenHi;
              result_o = '{code_unit: 16'd0, status: StBadC, last: 1'b1};
            end else begin
              if (rem == 16'd0) begin
                phase_d = PhLenHi;
              end
              result_o = '{code_unit: part_n, status: StChar, last: (rem == 16'd0)};
            end
          end
        end
      end
      default: begin
        phase_d = PhLenHi;
      end
    endcase
  end

endmodule

/* design/mutf8_queue.sv */
`timescale 1ns / 1ps

module mutf8_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mutf8_pkg::result_t  push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output mutf8_pkg::result_t  pop_data_o
);
  import mutf8_pkg::*;

  result_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]    wr_q, wr_d;
  logic [QueuePtrW-1:0]    rd_q, rd_d;
  logic [QueueCntW-1:0]    cnt_q, cnt_d;

  assign full_o     = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QueueCntW'(push_i) - QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* design/mutf8_back.sv */
`timescale 1ns / 1ps

module mutf8_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  mutf8_pkg::result_t  data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mutf8_pkg::result_t  out_data_o
);
  import mutf8_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign pop_o       = !empty_i && (!valid_q || !out_stall_i);
  assign valid_d     = pop_o || (valid_q && out_stall_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_i;
    end
  end

endmodule

/* design/modified_utf8_string_decoder.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  in_data_byte_i
// out       output     out_valid_o/out_stall_i out_code_unit_o, out_status_o, out_last_o
//
// One byte is accepted per cycle while the input is not stalled; the result that a
// byte completes is written into a queue entry and then registered in the output stage.
// Reset is asynchronous and active low; it clears the decode state and the queue.
// The input stalls only while the two-entry result queue is full.

module modified_utf8_string_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_code_unit_o,
  output logic [2:0]  out_status_o,
  output logic        out_last_o
);
  import mutf8_pkg::*;

  logic    take;
  logic    push;
  logic    full;
  logic    empty;
  logic    pop;
  result_t front_res;
  result_t queue_res;
  result_t out_res;

  assign in_stall_o = full;
  assign take       = in_valid_i && !full;

  mutf8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (in_data_byte_i),
    .push_o      (push),
    .result_o    (front_res)
  );

  mutf8_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take && push),
    .push_data_i (front_res),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (queue_res)
  );

  mutf8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .data_i      (queue_res),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign out_code_unit_o = out_res.code_unit;
  assign out_status_o    = out_res.status;
  assign out_last_o      = out_res.last;

endmodule
